>>> rtl/ccp_pkg.sv
package ccp_pkg;

  localparam int MAX_FIELD_LEN_DEF = 64;
  localparam int MAX_ARGS_DEF      = 8;

  localparam int CHAR_W  = 8;
  localparam int EVENT_W = 3;
  localparam int SLOT_W  = 3;
  localparam int POS_W   = 6;
  localparam int TOTAL_W = 4;

  // stored_char, argument_slot, char_position, argument_total, padded to bytes
  localparam int OUT_FIELDS_W = CHAR_W + SLOT_W + POS_W + TOTAL_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_OPEN   = 8'h28; // (
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2c; // ,
  localparam logic [CHAR_W-1:0] CH_CLOSE  = 8'h29; // )
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22; // "
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;

  typedef enum logic [EVENT_W-1:0] {
    EV_IGNORE      = 3'd0,
    EV_NAME_CHAR   = 3'd1,
    EV_ARG_CHAR    = 3'd2,
    EV_NAME_CLOSED = 3'd3,
    EV_ARG_CLOSED  = 3'd4,
    EV_SUCCESS     = 3'd5,
    EV_FAILURE     = 3'd6
  } event_t;

  typedef struct packed {
    event_t              event_code;
    logic [CHAR_W-1:0]   stored_char;
    logic [SLOT_W-1:0]   argument_slot;
    logic [POS_W-1:0]    char_position;
    logic [TOTAL_W-1:0]  argument_total;
  } result_t;

endpackage

>>> rtl/call_syntax_command_parser.sv
// Channel | Ports                    | Contents
// input   | in_tvalid/tready/tdata   | tdata[7:0] text_byte; tuser[0] start_flag
// result  | out_tvalid/tready/tdata  | tdata: char, slot, position, total; tuser: event
//
// One text byte per cycle sustained while results are accepted; a byte's event
// passes through the input register, then the result register.
// The parse state (phase, position, argument count) sits in the core and
// advances when the input register hands its byte on to the result register.
// Reset (rst_n low, synchronous) empties both registers and leaves the parser
// finished, so bytes are ignored until one arrives with start_flag set.
// A stalled result holds; the input register still takes one more byte.
module call_syntax_command_parser import ccp_pkg::*; #(
  parameter int MAX_FIELD_LEN = MAX_FIELD_LEN_DEF,
  parameter int MAX_ARGS      = MAX_ARGS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [CHAR_W-1:0]      in_tdata,   // [7:0] text_byte
  input  logic                   in_tuser,   // [0] start_flag
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] stored_char, [10:8] argument_slot,
                                             // [16:11] char_position,
                                             // [20:17] argument_total, rest zero
  output logic [EVENT_W-1:0]     out_tuser   // [2:0] event_code
);

  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_byte_r;
  logic              s1_start_r;
  logic              out_valid_r;
  result_t           out_res_r;
  result_t           core_res;
  logic              advance;
  logic              in_take;

  // Move the held byte on whenever the result register is free or draining.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  ccp_core #(
    .MAX_FIELD_LEN (MAX_FIELD_LEN),
    .MAX_ARGS      (MAX_ARGS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_go    (advance),
    .text_byte  (s1_byte_r),
    .start_flag (s1_start_r),
    .result     (core_res)
  );

  // Input register: hold the byte until the core takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  // Result register: load on advance, drop once the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.event_code;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                       out_res_r.argument_total,
                       out_res_r.char_position,
                       out_res_r.argument_slot,
                       out_res_r.stored_char};

endmodule

>>> rtl/ccp_core.sv
module ccp_core import ccp_pkg::*; #(
  parameter int MAX_FIELD_LEN = MAX_FIELD_LEN_DEF,
  parameter int MAX_ARGS      = MAX_ARGS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_go,
  input  logic [CHAR_W-1:0] text_byte,
  input  logic              start_flag,
  output result_t           result
);

  localparam int PW = $clog2(MAX_FIELD_LEN + 1);
  localparam int AW = $clog2(MAX_ARGS + 1);

  typedef enum logic [1:0] {
    PH_NAME   = 2'd0,
    PH_ARGS   = 2'd1,
    PH_QUOTED = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  phase_t          phase_r, phase_nxt, ph_eff;
  logic [PW-1:0]   pos_cnt_r, pos_cnt_nxt, pos_eff, pos_inc;
  logic [AW-1:0]   arg_cnt_r, arg_cnt_nxt, arg_eff, arg_inc;

  always_comb begin
    ph_eff  = start_flag ? PH_NAME : phase_r;
    pos_eff = start_flag ? '0 : pos_cnt_r;
    arg_eff = start_flag ? '0 : arg_cnt_r;
    pos_inc = pos_eff + PW'(1);
    arg_inc = arg_eff + AW'(1);

    phase_nxt   = ph_eff;
    pos_cnt_nxt = pos_eff;
    arg_cnt_nxt = arg_eff;
    result      = '{EV_IGNORE, '0, '0, '0, '0};

    if (ph_eff == PH_DONE) begin
      // finished: hold everything
    end else if (text_byte == CH_NUL || pos_eff >= PW'(MAX_FIELD_LEN)) begin
      phase_nxt         = PH_DONE;
      result.event_code = EV_FAILURE;
    end else begin
      unique case (ph_eff)
        PH_NAME: begin
          if (text_byte == CH_OPEN) begin
            result.event_code    = EV_NAME_CLOSED;
            result.char_position = POS_W'(pos_eff);
            phase_nxt            = PH_ARGS;
            pos_cnt_nxt          = '0;
          end else begin
            result.event_code    = EV_NAME_CHAR;
            result.stored_char   = text_byte;
            result.char_position = POS_W'(pos_eff);
            pos_cnt_nxt          = pos_inc;
          end
        end
        PH_ARGS: begin
          if (text_byte == CH_COMMA) begin
            arg_cnt_nxt = arg_inc;
            pos_cnt_nxt = '0;
            if (arg_inc >= AW'(MAX_ARGS)) begin
              phase_nxt         = PH_DONE;
              result.event_code = EV_FAILURE;
            end else begin
              result.event_code    = EV_ARG_CLOSED;
              result.argument_slot = SLOT_W'(arg_eff);
              result.char_position = POS_W'(pos_eff);
            end
          end else if (text_byte == CH_CLOSE) begin
            result.event_code     = EV_SUCCESS;
            result.argument_slot  = SLOT_W'(arg_eff);
            result.char_position  = POS_W'(pos_eff);
            result.argument_total = TOTAL_W'(arg_inc);
            phase_nxt             = PH_DONE;
          end else if (text_byte == CH_QUOTE) begin
            phase_nxt = PH_QUOTED;
          end else if (text_byte == CH_SPACE) begin
            // drop spaces outside quotes
          end else begin
            result.event_code    = EV_ARG_CHAR;
            result.stored_char   = text_byte;
            result.argument_slot = SLOT_W'(arg_eff);
            result.char_position = POS_W'(pos_eff);
            pos_cnt_nxt          = pos_inc;
          end
        end
        PH_QUOTED: begin
          if (text_byte == CH_QUOTE) begin
            phase_nxt = PH_ARGS;
          end else begin
            result.event_code    = EV_ARG_CHAR;
            result.stored_char   = text_byte;
            result.argument_slot = SLOT_W'(arg_eff);
            result.char_position = POS_W'(pos_eff);
            pos_cnt_nxt          = pos_inc;
          end
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_DONE;
      pos_cnt_r <= '0;
      arg_cnt_r <= '0;
    end else if (item_go) begin
      phase_r   <= phase_nxt;
      pos_cnt_r <= pos_cnt_nxt;
      arg_cnt_r <= arg_cnt_nxt;
    end
  end

  a_fail_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    item_go && result.event_code == EV_FAILURE |=> phase_r == PH_DONE)
    else $error("failure did not finish the command");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    item_go && phase_r == PH_DONE && !start_flag |=> $stable(pos_cnt_r) && $stable(arg_cnt_r))
    else $error("counters moved after finish");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    item_go && result.event_code != EV_FAILURE |=> pos_cnt_r <= PW'(MAX_FIELD_LEN))
    else $error("position count beyond field length");

  a_args_bound: assert property (@(posedge clk) disable iff (!rst_n)
    item_go && phase_nxt != PH_DONE |=> arg_cnt_r < AW'(MAX_ARGS))
    else $error("argument count reached limit while parsing");

endmodule

>>> sim/tb_call_syntax_command_parser.sv
`timescale 1ns / 1ps

import ccp_pkg::*;

// Scanner phases of the command text predictor
typedef enum logic [1:0] {
  SCAN_NAME,
  SCAN_ARGS,
  SCAN_QUOTED,
  SCAN_IDLE
} scan_phase_t;

class call_event_scoreboard;
  scan_phase_t scan;
  int unsigned field_len;
  int unsigned args_closed;
  result_t     awaited_events[$];
  int unsigned fail_count;

  function new();
    scan        = SCAN_IDLE;
    field_len   = 0;
    args_closed = 0;
    fail_count  = 0;
  endfunction

  function void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // Advance the scanner by one byte and return the event it reports
  function result_t next_event(logic [CHAR_W-1:0] c, logic first);
    result_t ev;
    ev = '0;
    if (first) begin
      scan        = SCAN_NAME;
      field_len   = 0;
      args_closed = 0;
    end
    if (scan == SCAN_IDLE) begin
      ev.event_code = EV_IGNORE;
    end else if (c == CH_NUL || field_len >= MAX_FIELD_LEN_DEF) begin
      ev.event_code = EV_FAILURE;
      scan          = SCAN_IDLE;
    end else if (scan == SCAN_NAME) begin
      if (c == CH_OPEN) begin
        ev.event_code    = EV_NAME_CLOSED;
        ev.char_position = POS_W'(field_len);
        scan             = SCAN_ARGS;
        field_len        = 0;
      end else begin
        ev.event_code    = EV_NAME_CHAR;
        ev.stored_char   = c;
        ev.char_position = POS_W'(field_len);
        field_len++;
      end
    end else if (scan == SCAN_ARGS) begin
      if (c == CH_COMMA) begin
        ev.argument_slot = SLOT_W'(args_closed);
        ev.char_position = POS_W'(field_len);
        args_closed++;
        field_len = 0;
        if (args_closed >= MAX_ARGS_DEF) begin
          ev            = '0;
          ev.event_code = EV_FAILURE;
          scan          = SCAN_IDLE;
        end else begin
          ev.event_code = EV_ARG_CLOSED;
        end
      end else if (c == CH_CLOSE) begin
        ev.event_code     = EV_SUCCESS;
        ev.argument_slot  = SLOT_W'(args_closed);
        ev.char_position  = POS_W'(field_len);
        ev.argument_total = TOTAL_W'(args_closed + 1);
        scan              = SCAN_IDLE;
      end else if (c == CH_QUOTE) begin
        ev.event_code = EV_IGNORE;
        scan          = SCAN_QUOTED;
      end else if (c == CH_SPACE) begin
        ev.event_code = EV_IGNORE;
      end else begin
        ev.event_code    = EV_ARG_CHAR;
        ev.stored_char   = c;
        ev.argument_slot = SLOT_W'(args_closed);
        ev.char_position = POS_W'(field_len);
        field_len++;
      end
    end else begin
      if (c == CH_QUOTE) begin
        ev.event_code = EV_IGNORE;
        scan          = SCAN_ARGS;
      end else begin
        ev.event_code    = EV_ARG_CHAR;
        ev.stored_char   = c;
        ev.argument_slot = SLOT_W'(args_closed);
        ev.char_position = POS_W'(field_len);
        field_len++;
      end
    end
    return ev;
  endfunction

  function void note_input(logic [CHAR_W-1:0] c, logic first);
    awaited_events.push_back(next_event(c, first));
  endfunction

  function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic [EVENT_W-1:0] tuser);
    result_t want;
    result_t got;
    got.event_code     = event_t'(tuser);
    got.stored_char    = tdata[7:0];
    got.argument_slot  = tdata[10:8];
    got.char_position  = tdata[16:11];
    got.argument_total = tdata[20:17];
    if (awaited_events.size() == 0) begin
      note_failure($sformatf("unexpected result: ev=%0d ch=%02h slot=%0d pos=%0d total=%0d",
                             got.event_code, got.stored_char, got.argument_slot,
                             got.char_position, got.argument_total));
    end else begin
      want = awaited_events.pop_front();
      if (got.event_code !== want.event_code || got.stored_char !== want.stored_char ||
          got.argument_slot !== want.argument_slot ||
          got.char_position !== want.char_position ||
          got.argument_total !== want.argument_total) begin
        note_failure({
          $sformatf("mismatch: expected ev=%0d ch=%02h slot=%0d pos=%0d total=%0d",
                    want.event_code, want.stored_char, want.argument_slot,
                    want.char_position, want.argument_total),
          $sformatf(", got ev=%0d ch=%02h slot=%0d pos=%0d total=%0d",
                    got.event_code, got.stored_char, got.argument_slot,
                    got.char_position, got.argument_total)});
      end
    end
  endfunction

  function int unsigned outstanding();
    return awaited_events.size();
  endfunction

  function void close_out();
    if (awaited_events.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", awaited_events.size()));
  endfunction
endclass

module tb_call_syntax_command_parser;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [CHAR_W-1:0]      in_tdata;   // [7:0] text_byte
  logic                   in_tuser;   // [0] start_flag
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [7:0] stored_char, [10:8] argument_slot,
                                      // [16:11] char_position, [20:17] argument_total
  logic [EVENT_W-1:0]     out_tuser;  // [2:0] event_code

  // Bit 8 carries the start flag, bits 7:0 the text byte
  logic [8:0]  text_q[$];
  int unsigned accepted;
  bit          steady;      // suppresses idling on both sides
  bit          held_off;

  call_event_scoreboard sb = new();

  call_syntax_command_parser #(
    .MAX_FIELD_LEN (MAX_FIELD_LEN_DEF),
    .MAX_ARGS      (MAX_ARGS_DEF)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 10 ns clock, rising edges at 5, 15, 25 ...
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Queue a string; only its first byte carries the start flag
  task automatic push_text(input string s, input logic first);
    int i;
    for (i = 0; i < s.len(); i++) begin
      text_q.push_back({(i == 0) ? first : 1'b0, s[i]});
    end
  endtask

  // Build one command, mostly well formed: name, '(', arguments, ')'.
  // Some fields run long enough to hit the length limit, some argument lists
  // are long enough to trip the argument limit, and a share of the commands
  // is broken by a stray zero byte or cut short.
  task automatic gen_command();
    logic [8:0]        cmd[$];
    int                name_len;
    int                n_args;
    int                arg_len;
    int                i;
    int                a;
    int                k;
    int                roll;
    logic [CHAR_W-1:0] c;
    roll = $urandom_range(0, 99);
    if (roll < 6)       name_len = $urandom_range(62, 66);
    else if (roll < 12) name_len = 0;
    else                name_len = $urandom_range(1, 8);
    for (i = 0; i < name_len; i++) begin
      do c = CHAR_W'($urandom_range(1, 255)); while (c == CH_OPEN);
      cmd.push_back({1'b0, c});
    end
    cmd.push_back({1'b0, CH_OPEN});
    if ($urandom_range(0, 99) < 10) n_args = $urandom_range(7, 9);
    else                            n_args = $urandom_range(1, 5);
    for (a = 0; a < n_args; a++) begin
      if (a > 0) cmd.push_back({1'b0, CH_COMMA});
      arg_len = ($urandom_range(0, 99) < 6) ? $urandom_range(62, 66) : $urandom_range(0, 6);
      if ($urandom_range(0, 99) < 30) begin
        // quoted argument: anything but the closing quote is stored
        cmd.push_back({1'b0, CH_QUOTE});
        for (i = 0; i < arg_len; i++) begin
          do c = CHAR_W'($urandom_range(1, 255)); while (c == CH_QUOTE);
          cmd.push_back({1'b0, c});
        end
        cmd.push_back({1'b0, CH_QUOTE});
      end else begin
        for (i = 0; i < arg_len; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            cmd.push_back({1'b0, CH_SPACE});
          end else begin
            do c = CHAR_W'($urandom_range(33, 255));
            while (c == CH_COMMA || c == CH_CLOSE || c == CH_QUOTE);
            cmd.push_back({1'b0, c});
          end
        end
      end
    end
    cmd.push_back({1'b0, CH_CLOSE});
    cmd[0][8] = 1'b1;
    if ($urandom_range(0, 99) < 15) begin
      if ($urandom_range(0, 1) == 1) begin
        cmd.insert($urandom_range(1, cmd.size() - 1), {1'b0, CH_NUL});
      end else begin
        k = $urandom_range(1, cmd.size() - 1);
        while (cmd.size() > k) void'(cmd.pop_back());
      end
    end
    foreach (cmd[n]) text_q.push_back(cmd[n]);
    // trailing bytes after the close are ignored by the parser
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) text_q.push_back({1'b0, CHAR_W'($urandom)});
  endtask

  // Offer one byte and hold it until the transaction completes.
  // Called at a falling edge; returns at a falling edge.
  task automatic send_byte(input logic [8:0] item);
    while (!steady && $urandom_range(0, 99) < 19) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= item[7:0];
    in_tuser  <= item[8];
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(item[7:0], item[8]);
    accepted++;
    steady = (accepted >= 600 && accepted < 800);
    @(negedge clk);
  endtask

  // Stimulus and end of run
  initial begin
    int drain;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    accepted  = 0;
    steady    = 1'b0;
    held_off  = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: name holding space, quote and ')', quoted argument with space
    // and comma, dropped space, two arguments closed by ')'
    push_text("a \")(\" ,\" x,)", 1'b1);
    // bytes after the finish, zero byte among them, are ignored
    text_q.push_back({1'b0, 8'h7a});
    text_q.push_back({1'b0, CH_NUL});
    // restart on the top byte value, then end the string early
    text_q.push_back({1'b1, 8'hff});
    text_q.push_back({1'b0, CH_NUL});
    // too many arguments: the eighth comma fails
    push_text("f(,,,,,,,,", 1'b1);
    // zero byte as the very first byte of a command
    text_q.push_back({1'b1, CH_NUL});

    // Random: mostly commands with random content, some loose noise bytes
    while (text_q.size() < 1380) begin
      if ($urandom_range(0, 99) < 10)
        text_q.push_back({($urandom_range(0, 7) == 0) ? 1'b1 : 1'b0, CHAR_W'($urandom)});
      else
        gen_command();
    end

    while (text_q.size() != 0) send_byte(text_q.pop_front());
    in_tvalid <= 1'b0;

    // Drain the remaining results, then allow for the pipeline depth
    drain = 0;
    while (sb.outstanding() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    sb.close_out();
    if (sb.fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: random back-pressure, one long hold-off to fill the block
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && !held_off && accepted >= 300) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (150) @(negedge clk);
      end
      out_tready <= steady || ($urandom_range(0, 99) >= 19);
    end
  end

  // Check each result transaction at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // Guard against a hung handshake
  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
